@@ rtl/ppst_pkg.sv @@
package ppst_pkg;

    localparam int MAX_WAYPOINTS_DEF = 1024;
    localparam int CORDIC_STEPS_DEF  = 16;

    localparam int XY_W   = 48;   // CORDIC x/y datapath
    localparam int ANG_W  = 36;   // binary angle, 2^32 per turn
    localparam int MUL_W  = 34;   // multiplier operand
    localparam int PROD_W = 68;   // multiplier product
    localparam int DIST_W = 66;   // squared distance

    localparam logic signed [XY_W-1:0]  KINV_Q30     = 48'sd652032874;
    localparam logic signed [XY_W-1:0]  NORM_LIMIT   = 48'sd1099511627776;
    localparam logic signed [ANG_W-1:0] TURN_HALF    = 36'sd2147483648;
    localparam logic signed [ANG_W-1:0] TURN_QUARTER = 36'sd1073741824;
    localparam logic [MUL_W-1:0]        PI_Q29       = 34'd1686629713;
    localparam logic [MUL_W-1:0]        DIV5_MAGIC   = 34'd3435973837;

    localparam logic REG_LOOKAHEAD = 1'b0;
    localparam logic REG_SPEED     = 1'b1;

    typedef enum logic {
        CORD_VEC,
        CORD_ROT
    } t_cordic_mode;

    typedef struct packed {
        logic         start;
        t_cordic_mode mode;
    } t_cordic_req;

    function automatic logic [29:0] atan_entry(input logic [4:0] idx);
        case (idx)
            5'd0:  atan_entry = 30'd536870912;
            5'd1:  atan_entry = 30'd316933406;
            5'd2:  atan_entry = 30'd167458907;
            5'd3:  atan_entry = 30'd85004756;
            5'd4:  atan_entry = 30'd42667331;
            5'd5:  atan_entry = 30'd21354465;
            5'd6:  atan_entry = 30'd10679838;
            5'd7:  atan_entry = 30'd5340245;
            5'd8:  atan_entry = 30'd2670163;
            5'd9:  atan_entry = 30'd1335087;
            5'd10: atan_entry = 30'd667544;
            5'd11: atan_entry = 30'd333772;
            5'd12: atan_entry = 30'd166886;
            5'd13: atan_entry = 30'd83443;
            5'd14: atan_entry = 30'd41722;
            5'd15: atan_entry = 30'd20861;
            5'd16: atan_entry = 30'd10430;
            5'd17: atan_entry = 30'd5215;
            5'd18: atan_entry = 30'd2608;
            5'd19: atan_entry = 30'd1304;
            5'd20: atan_entry = 30'd652;
            5'd21: atan_entry = 30'd326;
            5'd22: atan_entry = 30'd163;
            5'd23: atan_entry = 30'd81;
            default: atan_entry = 30'd0;
        endcase
    endfunction

endpackage

@@ rtl/ppst_mul.sv @@
module ppst_mul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [ppst_pkg::MUL_W-1:0]  i_a,
    input  logic signed [ppst_pkg::MUL_W-1:0]  i_b,
    output logic                              o_done,
    output logic signed [ppst_pkg::PROD_W-1:0] o_p
);
    import ppst_pkg::*;

    typedef enum logic [1:0] {
        M_IDLE,
        M_LO,
        M_HI,
        M_SUM
    } t_mstate;

    t_mstate                  r_state;
    logic                     r_done;
    logic signed [MUL_W-1:0]  r_a;
    logic signed [MUL_W-1:0]  r_b;
    logic signed [51:0]       r_mp;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [17:0]       w_lo;
    logic signed [17:0]       w_hi;

    assign w_lo = {1'b0, r_b[16:0]};
    assign w_hi = {r_b[MUL_W-1], r_b[MUL_W-1:17]};

    // two 34x18 partial products, low half first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_a;
                        r_b     <= i_b;
                        r_state <= M_LO;
                    end
                end
                M_LO: begin
                    r_mp    <= r_a * w_lo;
                    r_state <= M_HI;
                end
                M_HI: begin
                    r_acc   <= PROD_W'(r_mp);
                    r_mp    <= r_a * w_hi;
                    r_state <= M_SUM;
                end
                M_SUM: begin
                    r_acc   <= r_acc + (PROD_W'(r_mp) <<< 17);
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

@@ rtl/ppst_cordic.sv @@
module ppst_cordic #(
    parameter int CORDIC_STEPS = ppst_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ppst_pkg::t_cordic_req            i_req,
    input  logic signed [ppst_pkg::XY_W-1:0]  i_x,
    input  logic signed [ppst_pkg::XY_W-1:0]  i_y,
    input  logic signed [ppst_pkg::ANG_W-1:0] i_ang,
    output logic                             o_done,
    output logic signed [ppst_pkg::ANG_W-1:0] o_z,
    output logic signed [ppst_pkg::XY_W-1:0]  o_y
);
    import ppst_pkg::*;

    localparam int SW = $clog2(CORDIC_STEPS + 1);

    typedef enum logic [1:0] {
        C_IDLE,
        C_NORM,
        C_ITER
    } t_cstate;

    t_cstate                 r_state;
    t_cordic_mode            r_mode;
    logic                    r_done;
    logic [SW-1:0]           r_i;
    logic signed [XY_W-1:0]  r_x;
    logic signed [XY_W-1:0]  r_y;
    logic signed [ANG_W-1:0] r_z;
    logic signed [XY_W-1:0]  w_xs;
    logic signed [XY_W-1:0]  w_ys;
    logic signed [ANG_W-1:0] w_at;
    logic                    w_small;
    logic                    w_down;

    assign w_xs    = r_x >>> r_i;
    assign w_ys    = r_y >>> r_i;
    assign w_at    = signed'(ANG_W'(atan_entry(5'(r_i))));
    assign w_small = (r_x < NORM_LIMIT) && (r_x > -NORM_LIMIT) &&
                     (r_y < NORM_LIMIT) && (r_y > -NORM_LIMIT);
    // w_down rotates counterclockwise: x -= y>>i, y += x>>i, z -= atan
    assign w_down  = (r_mode == CORD_VEC) ? (r_y < 0) : (r_z >= 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_req.start) begin
                        r_mode <= i_req.mode;
                        r_i    <= '0;
                        if (i_req.mode == CORD_VEC) begin
                            r_x <= i_x;
                            r_y <= i_y;
                            r_z <= '0;
                            if (i_x == 0 && i_y == 0) begin
                                r_done <= 1'b1;
                            end else begin
                                r_state <= C_NORM;
                            end
                        end else begin
                            r_x <= KINV_Q30;
                            r_y <= '0;
                            // fold into [-pi/2, pi/2]
                            if (i_ang > TURN_QUARTER) begin
                                r_z <= TURN_HALF - i_ang;
                            end else if (i_ang < -TURN_QUARTER) begin
                                r_z <= -TURN_HALF - i_ang;
                            end else begin
                                r_z <= i_ang;
                            end
                            r_state <= C_ITER;
                        end
                    end
                end
                C_NORM: begin
                    if (w_small) begin
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end else begin
                        if (r_x < 0) begin
                            r_z <= (r_y >= 0) ? TURN_HALF : -TURN_HALF;
                            r_x <= -r_x;
                            r_y <= -r_y;
                        end
                        r_state <= C_ITER;
                    end
                end
                C_ITER: begin
                    if (r_i == SW'(CORDIC_STEPS) || (r_mode == CORD_VEC && r_y == 0)) begin
                        r_done  <= 1'b1;
                        r_state <= C_IDLE;
                    end else begin
                        if (w_down) begin
                            r_x <= r_x - w_ys;
                            r_y <= r_y + w_xs;
                            r_z <= r_z - w_at;
                        end else begin
                            r_x <= r_x + w_ys;
                            r_y <= r_y - w_xs;
                            r_z <= r_z + w_at;
                        end
                        r_i <= r_i + SW'(1);
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_z    = r_z;
    assign o_y    = r_y;

endmodule

@@ rtl/pure_pursuit_steering.sv @@
// Pure pursuit steering. Load words (cmd 0) append a waypoint to a closed
// path of up to MAX_WAYPOINTS entries; loads past capacity are dropped. A
// pose word (cmd 1) runs a sequencer over one shared multiplier and one
// shared CORDIC unit: yaw from the quaternion, a nearest-waypoint scan, a
// forward lookahead scan with wraparound, heading atan2, sin, a divide by
// five and the final atan. The nearest scan visits all N waypoints loaded,
// the lookahead scan at most N. The block stalls its input while a pose is
// processed and gives one result word per pose, none when the path is
// empty. A finished result waits in an output register, so the next word is
// taken while it is held.
module pure_pursuit_steering #(
    parameter int MAX_WAYPOINTS = ppst_pkg::MAX_WAYPOINTS_DEF,
    parameter int CORDIC_STEPS  = ppst_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_cmd,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_pose_x,
    input  logic signed [31:0] i_pose_y,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [15:0] i_quat_w,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_steer_angle,
    output logic [15:0]        o_linear_speed,
    output logic signed [31:0] o_target_x,
    output logic signed [31:0] o_target_y,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ppst_pkg::*;

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_QGO,
        ST_QWAIT,
        ST_YAW,
        ST_YWAIT,
        ST_LGO,
        ST_LWAIT,
        ST_RD,
        ST_DXGO,
        ST_DXWAIT,
        ST_DYGO,
        ST_DYWAIT,
        ST_CMP,
        ST_HGO,
        ST_HWAIT,
        ST_SGO,
        ST_SWAIT,
        ST_NGO,
        ST_NWAIT,
        ST_AGO,
        ST_AWAIT,
        ST_CGO,
        ST_CWAIT,
        ST_OUT
    } t_state;

    t_state                  r_state;
    logic [30:0]             r_look;
    logic [15:0]             r_speed;
    logic [CW-1:0]           r_count;

    logic signed [31:0]      m_x [MAX_WAYPOINTS];
    logic signed [31:0]      m_y [MAX_WAYPOINTS];
    logic signed [31:0]      r_rdx;
    logic signed [31:0]      r_rdy;
    logic [AW-1:0]           r_addr;
    logic [AW-1:0]           r_i;
    logic                    r_scan2;

    logic signed [31:0]      r_px;
    logic signed [31:0]      r_py;
    logic signed [15:0]      r_qx;
    logic signed [15:0]      r_qy;
    logic signed [15:0]      r_qz;
    logic signed [15:0]      r_qw;
    logic [2:0]              r_k;
    logic signed [33:0]      r_n;
    logic signed [33:0]      r_s;
    logic signed [33:0]      r_m10;
    logic signed [33:0]      r_m20;
    logic signed [ANG_W-1:0] r_yaw;
    logic signed [ANG_W-1:0] r_head;
    logic signed [ANG_W-1:0] r_zs;
    logic [DIST_W-1:0]       r_l2;
    logic [DIST_W-1:0]       r_d;
    logic [DIST_W-1:0]       r_best;
    logic [AW-1:0]           r_near;
    logic signed [31:0]      r_nx;
    logic signed [31:0]      r_ny;
    logic signed [31:0]      r_tx;
    logic signed [31:0]      r_ty;
    logic                    r_neg;
    logic [33:0]             r_v;
    logic [29:0]             r_q;
    logic signed [15:0]      r_steer;

    logic                    r_ov;
    logic signed [15:0]      r_o_steer;
    logic [15:0]             r_o_speed;
    logic signed [31:0]      r_o_tx;
    logic signed [31:0]      r_o_ty;

    logic                    w_in_acc;
    logic                    w_load_wr;
    logic                    w_out_free;
    logic                    w_mul_start;
    logic signed [MUL_W-1:0] w_ma;
    logic signed [MUL_W-1:0] w_mb;
    logic                    w_mul_done;
    logic signed [PROD_W-1:0] w_mp;
    logic signed [33:0]      w_pq;
    logic signed [15:0]      w_qa;
    logic signed [15:0]      w_qb;
    t_cordic_req             w_creq;
    logic signed [XY_W-1:0]  w_cx;
    logic signed [XY_W-1:0]  w_cy;
    logic signed [ANG_W-1:0] w_cang;
    logic                    w_cdone;
    logic signed [ANG_W-1:0] w_cz;
    logic signed [XY_W-1:0]  w_cyo;
    logic signed [32:0]      w_dx;
    logic signed [32:0]      w_dy;
    logic signed [32:0]      w_tdx;
    logic signed [32:0]      w_tdy;
    logic signed [33:0]      w_m10;
    logic signed [33:0]      w_m00;
    logic signed [33:0]      w_m20;
    logic signed [33:0]      w_m20abs;
    logic                    w_gimbal;
    logic signed [36:0]      w_alpha_raw;
    logic signed [36:0]      w_alpha;
    logic signed [XY_W-1:0]  w_sabs;
    logic [33:0]             w_v;
    logic signed [XY_W-1:0]  w_num;
    logic signed [ANG_W-1:0] w_zmag;
    logic [63:0]             w_rnd;
    logic signed [15:0]      w_r;
    logic                    w_last;
    logic                    w_better;
    logic [AW-1:0]           w_near_n;

    assign w_in_acc   = i_valid && !o_stall;
    assign w_load_wr  = w_in_acc && !i_cmd && (r_count < CW'(MAX_WAYPOINTS));
    assign w_out_free = !r_ov || !i_stall;

    // path memory, one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_load_wr) begin
            m_x[r_count[AW-1:0]] <= i_point_x;
            m_y[r_count[AW-1:0]] <= i_point_y;
        end
        r_rdx <= m_x[r_addr];
        r_rdy <= m_y[r_addr];
    end

    assign w_dx  = {r_rdx[31], r_rdx} - {r_px[31], r_px};
    assign w_dy  = {r_rdy[31], r_rdy} - {r_py[31], r_py};
    assign w_tdx = {r_tx[31], r_tx} - {r_px[31], r_px};
    assign w_tdy = {r_ty[31], r_ty} - {r_py[31], r_py};

    always_comb begin
        unique case (r_k)
            3'd0:    begin w_qa = r_qx; w_qb = r_qx; end
            3'd1:    begin w_qa = r_qy; w_qb = r_qy; end
            3'd2:    begin w_qa = r_qz; w_qb = r_qz; end
            3'd3:    begin w_qa = r_qw; w_qb = r_qw; end
            3'd4:    begin w_qa = r_qx; w_qb = r_qy; end
            3'd5:    begin w_qa = r_qw; w_qb = r_qz; end
            3'd6:    begin w_qa = r_qx; w_qb = r_qz; end
            default: begin w_qa = r_qw; w_qb = r_qy; end
        endcase
    end

    assign w_sabs = (w_cyo < 0) ? -w_cyo : w_cyo;
    assign w_v    = {1'b0, w_sabs[32:0]} + {w_sabs[32:0], 1'b0};
    assign w_zmag = (r_zs < 0) ? -r_zs : r_zs;

    always_comb begin
        w_mul_start = 1'b0;
        w_ma        = '0;
        w_mb        = '0;
        priority case (r_state)
            ST_QGO: begin
                w_mul_start = 1'b1;
                w_ma        = MUL_W'(w_qa);
                w_mb        = MUL_W'(w_qb);
            end
            ST_LGO: begin
                w_mul_start = 1'b1;
                w_ma        = signed'({3'b000, r_look});
                w_mb        = signed'({3'b000, r_look});
            end
            ST_DXGO: begin
                w_mul_start = 1'b1;
                w_ma        = MUL_W'(w_dx);
                w_mb        = MUL_W'(w_dx);
            end
            ST_DYGO: begin
                w_mul_start = 1'b1;
                w_ma        = MUL_W'(w_dy);
                w_mb        = MUL_W'(w_dy);
            end
            ST_NGO: begin
                w_mul_start = 1'b1;
                w_ma        = signed'(r_v);
                w_mb        = signed'(DIV5_MAGIC);
            end
            ST_CGO: begin
                w_mul_start = 1'b1;
                w_ma        = signed'(w_zmag[MUL_W-1:0]);
                w_mb        = signed'(PI_Q29);
            end
            default: ;
        endcase
    end

    ppst_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mul_done),
        .o_p     (w_mp)
    );

    assign w_pq     = w_mp[33:0];
    assign w_m10    = r_m10 <<< 1;
    assign w_m00    = r_n - (r_s <<< 1);
    assign w_m20    = r_m20 <<< 1;
    assign w_m20abs = (w_m20 < 0) ? -w_m20 : w_m20;
    assign w_gimbal = (w_m20abs >= r_n);

    // heading error, wrapped once into [-pi, pi]
    assign w_alpha_raw = 37'(r_head) - 37'(r_yaw);
    always_comb begin
        if (w_alpha_raw > 37'sd2147483648) begin
            w_alpha = w_alpha_raw - 37'sd4294967296;
        end else if (w_alpha_raw < -37'sd2147483648) begin
            w_alpha = w_alpha_raw + 37'sd4294967296;
        end else begin
            w_alpha = w_alpha_raw;
        end
    end

    assign w_num = r_neg ? -signed'(XY_W'(r_q)) : signed'(XY_W'(r_q));

    always_comb begin
        w_creq.start = 1'b0;
        w_creq.mode  = CORD_VEC;
        w_cx         = '0;
        w_cy         = '0;
        w_cang       = '0;
        priority case (r_state)
            ST_YAW: begin
                w_creq.start = !w_gimbal;
                w_cx         = XY_W'(w_m00);
                w_cy         = XY_W'(w_m10);
            end
            ST_HGO: begin
                w_creq.start = 1'b1;
                w_cx         = XY_W'(w_tdx);
                w_cy         = XY_W'(w_tdy);
            end
            ST_SGO: begin
                w_creq.start = 1'b1;
                w_creq.mode  = CORD_ROT;
                w_cang       = w_alpha[ANG_W-1:0];
            end
            ST_AGO: begin
                w_creq.start = 1'b1;
                w_cx         = signed'(XY_W'({r_look, 14'b0}));
                w_cy         = w_num;
            end
            default: ;
        endcase
    end

    ppst_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_creq),
        .i_x     (w_cx),
        .i_y     (w_cy),
        .i_ang   (w_cang),
        .o_done  (w_cdone),
        .o_z     (w_cz),
        .o_y     (w_cyo)
    );

    assign w_rnd = w_mp[63:0] + (64'd1 << 46);
    assign w_r   = signed'(w_rnd[62:47]);

    assign w_last   = (CW'(r_i) == r_count - CW'(1));
    assign w_better = (r_i == '0) || (r_d < r_best);
    assign w_near_n = w_better ? r_i : r_near;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_look  <= 31'd131072;
            r_speed <= 16'd384;
            r_ov    <= 1'b0;
            r_addr  <= '0;
        end else begin
            if (psel && penable && pwrite) begin
                unique case (paddr[2])
                    REG_LOOKAHEAD: r_look  <= pwdata[30:0];
                    REG_SPEED:     r_speed <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_load_wr) begin
                        r_count <= r_count + CW'(1);
                    end
                    if (w_in_acc && i_cmd && r_count != '0) begin
                        r_px    <= i_pose_x;
                        r_py    <= i_pose_y;
                        r_qx    <= i_quat_x;
                        r_qy    <= i_quat_y;
                        r_qz    <= i_quat_z;
                        r_qw    <= i_quat_w;
                        r_n     <= '0;
                        r_s     <= '0;
                        r_m10   <= '0;
                        r_m20   <= '0;
                        r_k     <= '0;
                        r_state <= ST_QGO;
                    end
                end
                ST_QGO: r_state <= ST_QWAIT;
                ST_QWAIT: begin
                    if (w_mul_done) begin
                        priority case (r_k)
                            3'd0, 3'd3: r_n <= r_n + w_pq;
                            3'd1, 3'd2: begin
                                r_n <= r_n + w_pq;
                                r_s <= r_s + w_pq;
                            end
                            3'd4, 3'd5: r_m10 <= r_m10 + w_pq;
                            3'd6:       r_m20 <= r_m20 + w_pq;
                            default:    r_m20 <= r_m20 - w_pq;
                        endcase
                        r_k     <= r_k + 3'd1;
                        r_state <= (r_k == 3'd7) ? ST_YAW : ST_QGO;
                    end
                end
                ST_YAW: begin
                    if (w_gimbal) begin
                        r_yaw   <= '0;
                        r_state <= ST_LGO;
                    end else begin
                        r_state <= ST_YWAIT;
                    end
                end
                ST_YWAIT: begin
                    if (w_cdone) begin
                        r_yaw   <= w_cz;
                        r_state <= ST_LGO;
                    end
                end
                ST_LGO: r_state <= ST_LWAIT;
                ST_LWAIT: begin
                    if (w_mul_done) begin
                        r_l2    <= w_mp[DIST_W-1:0];
                        r_i     <= '0;
                        r_addr  <= '0;
                        r_scan2 <= 1'b0;
                        r_state <= ST_RD;
                    end
                end
                ST_RD:   r_state <= ST_DXGO;
                ST_DXGO: r_state <= ST_DXWAIT;
                ST_DXWAIT: begin
                    if (w_mul_done) begin
                        r_d     <= w_mp[DIST_W-1:0];
                        r_state <= ST_DYGO;
                    end
                end
                ST_DYGO: r_state <= ST_DYWAIT;
                ST_DYWAIT: begin
                    if (w_mul_done) begin
                        r_d     <= r_d + w_mp[DIST_W-1:0];
                        r_state <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    if (!r_scan2) begin
                        if (w_better) begin
                            r_best <= r_d;
                            r_near <= r_i;
                            r_nx   <= r_rdx;
                            r_ny   <= r_rdy;
                        end
                        if (w_last) begin
                            // start the lookahead scan at the nearest point
                            r_scan2 <= 1'b1;
                            r_i     <= '0;
                            r_addr  <= w_near_n;
                        end else begin
                            r_i    <= r_i + AW'(1);
                            r_addr <= r_addr + AW'(1);
                        end
                        r_state <= ST_RD;
                    end else if (r_d >= r_l2) begin
                        r_tx    <= r_rdx;
                        r_ty    <= r_rdy;
                        r_state <= ST_HGO;
                    end else if (w_last) begin
                        r_tx    <= r_nx;
                        r_ty    <= r_ny;
                        r_state <= ST_HGO;
                    end else begin
                        r_i <= r_i + AW'(1);
                        if (CW'(r_addr) == r_count - CW'(1)) begin
                            r_addr <= '0;
                        end else begin
                            r_addr <= r_addr + AW'(1);
                        end
                        r_state <= ST_RD;
                    end
                end
                ST_HGO: r_state <= ST_HWAIT;
                ST_HWAIT: begin
                    if (w_cdone) begin
                        r_head  <= w_cz;
                        r_state <= ST_SGO;
                    end
                end
                ST_SGO: r_state <= ST_SWAIT;
                ST_SWAIT: begin
                    if (w_cdone) begin
                        r_neg   <= (w_cyo < 0);
                        r_v     <= w_v;
                        r_state <= ST_NGO;
                    end
                end
                ST_NGO: r_state <= ST_NWAIT;
                ST_NWAIT: begin
                    if (w_mul_done) begin
                        // 3*|sin| / 5 by reciprocal
                        r_q     <= w_mp[63:34];
                        r_state <= ST_AGO;
                    end
                end
                ST_AGO: r_state <= ST_AWAIT;
                ST_AWAIT: begin
                    if (w_cdone) begin
                        r_zs    <= w_cz;
                        r_neg   <= (w_cz < 0);
                        r_state <= ST_CGO;
                    end
                end
                ST_CGO: r_state <= ST_CWAIT;
                ST_CWAIT: begin
                    if (w_mul_done) begin
                        r_steer <= r_neg ? -w_r : w_r;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_ov      <= 1'b1;
                        r_o_steer <= r_steer;
                        r_o_speed <= r_speed;
                        r_o_tx    <= r_tx;
                        r_o_ty    <= r_ty;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stall          = (r_state != ST_IDLE);
    assign o_valid          = r_ov;
    assign o_steer_angle    = r_o_steer;
    assign o_linear_speed   = r_o_speed;
    assign o_target_x       = r_o_tx;
    assign o_target_y       = r_o_ty;
    assign prdata           = (paddr[2] == REG_SPEED) ? {16'b0, r_speed} : {1'b0, r_look};
    assign pready           = 1'b1;

endmodule

@@ rtl/ppst_checker.sv @@
module ppst_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               i_cmd,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [15:0] o_steer_angle
);

    // reset leaves the block idle with nothing to deliver
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("block not idle after reset");

    // a waypoint load finishes in its own cycle
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_cmd |=> !o_stall)
        else $error("stalled after a waypoint load");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_steer_angle))
        else $error("stalled result word changed");

endmodule

bind pure_pursuit_steering ppst_checker u_ppst_checker (.*);

@@ verif/pure_pursuit_steering_checker.sv @@
module pure_pursuit_steering_checker #(
    parameter int MAX_WAYPOINTS = 1024,
    parameter int CORDIC_STEPS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic               i_cmd,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_pose_x,
    input  logic signed [31:0] i_pose_y,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [15:0] i_quat_w,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [15:0] o_steer_angle,
    input  logic [15:0]        o_linear_speed,
    input  logic signed [31:0] o_target_x,
    input  logic signed [31:0] o_target_y,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ppst_pkg::*;

    typedef struct packed {
        logic signed [15:0] steer;
        logic [15:0]        speed;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
    } t_steer_cmd;

    localparam longint HALF_TURN    = 64'sd2147483648;
    localparam longint QUARTER_TURN = 64'sd1073741824;
    localparam longint GAIN_INV     = 64'sd652032874;
    localparam longint SCALE_LIMIT  = 64'sd1099511627776;
    localparam longint PI_SCALE     = 64'sd1686629713;

    localparam longint STEP_ANGLE [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    logic signed [31:0] route_x [MAX_WAYPOINTS];
    logic signed [31:0] route_y [MAX_WAYPOINTS];
    int                 route_len;
    logic [30:0]        lookahead;
    logic [15:0]        speed_cmd;
    t_steer_cmd         steer_due [$];

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint vector_angle(input longint y_in, input longint x_in);
        longint x, y, z, nx, ny;
        x = x_in;
        y = y_in;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        while (mag(x) < SCALE_LIMIT && mag(y) < SCALE_LIMIT) begin
            x = x * 2;
            y = y * 2;
        end
        if (x < 0) begin
            z = (y >= 0) ? HALF_TURN : -HALF_TURN;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += STEP_ANGLE[i];
            end else if (y < 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= STEP_ANGLE[i];
            end else begin
                break;
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    function automatic longint sine_q30(input longint a_in);
        longint a, x, y, nx, ny;
        a = a_in;
        x = GAIN_INV;
        y = 0;
        // fold into [-pi/2, pi/2]
        if (a > QUARTER_TURN)
            a = HALF_TURN - a;
        else if (a < -QUARTER_TURN)
            a = -HALF_TURN - a;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            if (a >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                a -= STEP_ANGLE[i];
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                a += STEP_ANGLE[i];
            end
            x = nx;
            y = ny;
        end
        return y;
    endfunction

    function automatic logic signed [15:0] to_q313(input longint a);
        longint unsigned p, r;
        p = longint'(mag(a)) * PI_SCALE;
        r = (p + (64'd1 << 46)) >> 47;
        return (a < 0) ? -16'(r) : 16'(r);
    endfunction

    function automatic logic [65:0] range_sq(input int k, input longint px, input longint py);
        longint unsigned ax, ay;
        ax = mag(longint'(route_x[k]) - px);
        ay = mag(longint'(route_y[k]) - py);
        return 66'(ax * ax) + 66'(ay * ay);
    endfunction

    function automatic t_steer_cmd pursue(input longint px, input longint py,
                                          input longint qx, input longint qy,
                                          input longint qz, input longint qw);
        t_steer_cmd r;
        longint n, m10, m00, m20, yaw, head, alpha, sn;
        logic [65:0] d, best, reach;
        int near, tgt, k;
        n   = qx * qx + qy * qy + qz * qz + qw * qw;
        m10 = 2 * (qx * qy + qw * qz);
        m00 = n - 2 * (qy * qy + qz * qz);
        m20 = 2 * (qx * qz - qw * qy);
        // gimbal lock or zero quaternion: no yaw
        yaw = (mag(m20) >= n) ? 0 : vector_angle(m10, m00);
        near = 0;
        best = '0;
        for (int i = 0; i < route_len; i++) begin
            d = range_sq(i, px, py);
            if (i == 0 || d < best) begin
                best = d;
                near = i;
            end
        end
        reach = 66'(longint'(lookahead) * longint'(lookahead));
        tgt = near;
        for (int i = 0; i < route_len; i++) begin
            k = near + i;
            if (k >= route_len)
                k -= route_len;
            if (range_sq(k, px, py) >= reach) begin
                tgt = k;
                break;
            end
        end
        head  = vector_angle(longint'(route_y[tgt]) - py, longint'(route_x[tgt]) - px);
        alpha = head - yaw;
        if (alpha > HALF_TURN)
            alpha -= 2 * HALF_TURN;
        else if (alpha < -HALF_TURN)
            alpha += 2 * HALF_TURN;
        sn = sine_q30(alpha);
        r.steer = to_q313(vector_angle((sn * 3) / 5, longint'(lookahead) * 16384));
        r.speed = speed_cmd;
        r.tx    = route_x[tgt];
        r.ty    = route_y[tgt];
        return r;
    endfunction

    task automatic match_field(input string name, input longint want, input longint got);
        if (want != got) begin
            o_fail_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    assign o_pending = steer_due.size();

    always @(posedge i_clk) begin
        t_steer_cmd want;
        if (!i_rst_n) begin
            route_len    <= 0;
            lookahead    <= 31'd131072;
            speed_cmd    <= 16'd384;
            o_fail_count <= 0;
            steer_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_SPEED)
                    speed_cmd <= pwdata[15:0];
                else
                    lookahead <= pwdata[30:0];
            end
            if (o_valid && !i_stall) begin
                if (steer_due.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result steering %0d target %0d,%0d", $time,
                             o_steer_angle, o_target_x, o_target_y);
                end else begin
                    want = steer_due.pop_front();
                    match_field("steer_angle", want.steer, o_steer_angle);
                    match_field("linear_speed", want.speed, o_linear_speed);
                    match_field("target_x", want.tx, o_target_x);
                    match_field("target_y", want.ty, o_target_y);
                end
            end
            if (i_valid && !o_stall) begin
                if (!i_cmd) begin
                    if (route_len < MAX_WAYPOINTS) begin
                        route_x[route_len] = i_point_x;
                        route_y[route_len] = i_point_y;
                        route_len <= route_len + 1;
                    end
                end else if (route_len != 0) begin
                    steer_due.insert(steer_due.size(),
                                     pursue(i_pose_x, i_pose_y, i_quat_x, i_quat_y,
                                            i_quat_z, i_quat_w));
                end
            end
        end
    end

endmodule

@@ verif/pure_pursuit_steering_test.sv @@
module pure_pursuit_steering_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ppst_pkg::*;

    localparam int CMD_LOAD = 0;
    localparam int CMD_POSE = 1;
    localparam int TABLE_SIZE = 1024;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_cmd = 1'b0;
    logic signed [31:0] i_point_x = '0;
    logic signed [31:0] i_point_y = '0;
    logic signed [31:0] i_pose_x = '0;
    logic signed [31:0] i_pose_y = '0;
    logic signed [15:0] i_quat_x = '0;
    logic signed [15:0] i_quat_y = '0;
    logic signed [15:0] i_quat_z = '0;
    logic signed [15:0] i_quat_w = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_steer_angle;
    logic [15:0]        o_linear_speed;
    logic signed [31:0] o_target_x;
    logic signed [31:0] o_target_y;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;
    int                 loaded = 0;
    bit                 quiet = 1'b0;
    int                 stall_left = 0;

    pure_pursuit_steering dut (.*);

    pure_pursuit_steering_checker chk (
        .*,
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    always #4 i_clk = ~i_clk;

    // receiver back-pressure in bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 10);
            i_stall = 1'b1;
        end else begin
            i_stall = 1'b0;
        end
    end

    task automatic send_word(input int cmd, input logic [31:0] ax, input logic [31:0] ay,
                             input logic [31:0] bx, input logic [31:0] by,
                             input logic [15:0] qx, input logic [15:0] qy,
                             input logic [15:0] qz, input logic [15:0] qw);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_cmd     = cmd[0];
        i_point_x = ax;
        i_point_y = ay;
        i_pose_x  = bx;
        i_pose_y  = by;
        i_quat_x  = qx;
        i_quat_y  = qy;
        i_quat_z  = qz;
        i_quat_w  = qw;
        i_valid   = 1'b1;
        do @(posedge i_clk); while (o_stall);
        if (cmd == CMD_LOAD && loaded < TABLE_SIZE)
            loaded++;
    endtask

    task automatic add_point(input logic [31:0] x, input logic [31:0] y);
        send_word(CMD_LOAD, x, y, $urandom, $urandom, 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
    endtask

    task automatic pose(input logic [31:0] x, input logic [31:0] y, input logic [15:0] qx,
                        input logic [15:0] qy, input logic [15:0] qz, input logic [15:0] qw);
        send_word(CMD_POSE, $urandom, $urandom, x, y, qx, qy, qz, qw);
    endtask

    function automatic logic [31:0] coord();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $urandom_range(0, 40 << 16) - (20 << 16);
    endfunction

    function automatic logic [15:0] quat_part();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'h4000;
            2: return 16'hC000;
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    // drain, then let a result-less pose finish before touching registers
    task automatic settle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (24 * loaded + 600) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic reg_sel, input logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = {reg_sel, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    initial begin
        #20_000_000;
        $display("FAIL pure_pursuit_steering");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty path gives nothing
        pose(0, 0, 0, 0, 0, 16384);
        add_point(0, 0);
        add_point(10 << 16, 0);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_point(32'h8000_0000, 32'h8000_0000);
        add_point(-(5 << 16), 3 << 16);
        pose(0, 0, 0, 0, 0, 16384);
        pose(1 << 16, 1 << 16, 0, 0, 0, 0);
        pose(2 << 16, 0, 0, 11585, 0, 11585);
        pose(-(1 << 16), 2 << 16, 16'hC000, 16'hC000, 16'hC000, 16'hC000);
        pose(0, -(1 << 16), 0, 0, 16384, 0);
        // waypoint straight behind: heading error of exactly a half turn
        pose(20 << 16, 0, 0, 0, 0, 16384);
        pose(32'h8000_0000, 32'h7FFF_FFFF, 16384, 16384, 16384, 16384);
        settle();
        reg_write(REG_LOOKAHEAD, 32'd1);
        reg_write(REG_SPEED, 32'd0);
        pose(3 << 16, 4 << 16, 1000, 16'hF830, 9000, 12000);
        pose(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 16'hC000, 0);
        settle();
        reg_write(REG_LOOKAHEAD, 32'h7FFF_FFFF);
        reg_write(REG_SPEED, 32'hFFFF);
        pose(0, 0, 0, 0, 8000, 14000);
        pose(32'h8000_0000, 32'h8000_0000, 0, 0, 0, 16384);

        for (int phase = 0; phase < 4; phase++) begin
            settle();
            reg_write(REG_LOOKAHEAD, ($urandom_range(0, 2) == 0)
                      ? $urandom_range(1, 32'h7FFF_FFFF) : $urandom_range(1, 12 << 16));
            reg_write(REG_SPEED, $urandom_range(0, 16'hFFFF));
            if (phase == 3)
                quiet = 1'b1;
            for (int k = 0; k < 30; k++) begin
                if ($urandom_range(0, 2) == 0)
                    add_point(coord(), coord());
                else
                    pose(coord(), coord(), quat_part(), quat_part(), quat_part(),
                         quat_part());
            end
        end

        settle();
        reg_write(REG_LOOKAHEAD, $urandom_range(1, 8 << 16));
        for (int k = 0; k < 3; k++)
            pose(coord(), coord(), quat_part(), quat_part(), quat_part(), quat_part());
        settle();

        if (fail_count == 0 && pending == 0)
            $display("PASS pure_pursuit_steering");
        else
            $display("FAIL pure_pursuit_steering");
        $finish;
    end

endmodule
